@@ rtl/core/nsc_pkg.sv @@
// Shared types and constants for the spoken-number clip sequencer.
// Used by the front end, the request queue, the back end and the top level.
package nsc_pkg;

    // Clip codes beyond the plain digits 0-9.
    localparam logic [7:0] CODE_MINUS    = 8'd10;
    localparam logic [7:0] CODE_POINT    = 8'd11;
    localparam logic [7:0] CODE_THOUSAND = 8'd12;
    localparam logic [7:0] CODE_HUNDRED  = 8'd13;
    localparam logic [7:0] CODE_TEN      = 8'd14;

    // Request types.
    localparam logic [1:0] REQ_RAW    = 2'd0;
    localparam logic [1:0] REQ_INT    = 2'd1;
    localparam logic [1:0] REQ_TENTHS = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam int MAX_CODES = 10;
    localparam int CNT_W     = 4;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;

    // One request, fully expanded into its clip codes.
    typedef struct packed {
        logic [MAX_CODES-1:0][7:0] codes;
        logic [CNT_W-1:0]          cnt;
        logic [7:0]                gap;
    } entry_t;

endpackage

@@ rtl/core/nsc_front.sv @@
// Front end: accepts requests, splits the magnitude into decimal digits
// in a six-stage pipeline and builds the clip list. Depends on nsc_pkg.
module nsc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic signed [17:0]  s_value,
    input  logic [7:0]          s_word_gap_ms,
    input  logic                q_full,
    output logic                q_push,
    output nsc_pkg::entry_t     q_entry
);
    import nsc_pkg::*;

    localparam int NSTG = 6;

    typedef struct packed {
        logic [1:0]  rtype;
        logic        neg;
        logic [7:0]  raw;
        logic [7:0]  gap;
        logic [17:0] work;
        logic [3:0]  dec;
        logic [3:0]  a0;
        logic [3:0]  a1;
        logic [3:0]  a2;
        logic [3:0]  a3;
    } stage_t;

    stage_t            st_reg  [NSTG];
    stage_t            st_next [NSTG];
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   vld_next;
    logic              adv;
    entry_t            ent;

    // x / 10 by reciprocal multiply; exact for every 18-bit x.
    function automatic logic [17:0] div10(input logic [17:0] x);
        logic [35:0] p;
        begin
            p = {18'd0, x} * 36'd209716;
            return {3'd0, p[35:21]};
        end
    endfunction

    function automatic logic [3:0] rem10(input logic [17:0] x, input logic [17:0] q);
        logic [17:0] r;
        begin
            r = x - ((q << 3) + (q << 1));
            return r[3:0];
        end
    endfunction

    // The whole pipeline holds when the last stage cannot hand off.
    assign adv      = !(vld_reg[NSTG-1] && q_full);
    assign s_ready  = adv;
    assign vld_next = {vld_reg[NSTG-2:0], s_valid};

    always_comb begin
        logic [17:0] v;
        logic [17:0] q;
        v = s_value;
        st_next[0]       = '0;
        st_next[0].rtype = s_req_type;
        st_next[0].neg   = v[17];
        st_next[0].raw   = v[7:0];
        st_next[0].gap   = s_word_gap_ms;
        st_next[0].work  = v[17] ? (~v + 18'd1) : v;

        st_next[1] = st_reg[0];
        if (st_reg[0].rtype == REQ_TENTHS) begin
            q = div10(st_reg[0].work);
            st_next[1].dec  = rem10(st_reg[0].work, q);
            st_next[1].work = q;
        end

        q = div10(st_reg[1].work);
        st_next[2]      = st_reg[1];
        st_next[2].a0   = rem10(st_reg[1].work, q);
        st_next[2].work = q;

        q = div10(st_reg[2].work);
        st_next[3]      = st_reg[2];
        st_next[3].a1   = rem10(st_reg[2].work, q);
        st_next[3].work = q;

        q = div10(st_reg[3].work);
        st_next[4]      = st_reg[3];
        st_next[4].a2   = rem10(st_reg[3].work, q);
        st_next[4].work = q;

        q = div10(st_reg[4].work);
        st_next[5]      = st_reg[4];
        st_next[5].a3   = rem10(st_reg[4].work, q);
        st_next[5].work = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NSTG; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Build the raw clip, or speak the four places and the tenths digit.
    always_comb begin
        stage_t           s;
        logic [CNT_W-1:0] n;
        logic             skip;
        s    = st_reg[NSTG-1];
        n    = '0;
        skip = 1'b0;
        ent  = '0;
        ent.gap = s.gap;
        case (s.rtype)
            REQ_RAW: begin
                ent.codes[0] = s.raw;
                n = 4'd1;
            end
            REQ_INT, REQ_TENTHS: begin
                if (s.neg) begin
                    ent.codes[n] = CODE_MINUS; n = n + 4'd1;
                end
                if (s.a3 != 4'd0) begin
                    ent.codes[n] = {4'd0, s.a3}; n = n + 4'd1;
                    ent.codes[n] = CODE_THOUSAND; n = n + 4'd1;
                end
                if (s.a2 != 4'd0) begin
                    ent.codes[n] = {4'd0, s.a2}; n = n + 4'd1;
                    ent.codes[n] = CODE_HUNDRED; n = n + 4'd1;
                end else if (s.a3 != 4'd0) begin
                    if (s.a1 == 4'd0 && s.a0 == 4'd0) begin
                        skip = 1'b1;
                    end else begin
                        ent.codes[n] = 8'd0; n = n + 4'd1;
                    end
                end
                if (!skip) begin
                    if (s.a1 != 4'd0) begin
                        // A bare "ten" drops its leading one.
                        if (s.a1 != 4'd1 || s.a3 != 4'd0 || s.a2 != 4'd0) begin
                            ent.codes[n] = {4'd0, s.a1}; n = n + 4'd1;
                        end
                        ent.codes[n] = CODE_TEN; n = n + 4'd1;
                    end else if (s.a2 != 4'd0) begin
                        if (s.a0 == 4'd0) begin
                            skip = 1'b1;
                        end else begin
                            ent.codes[n] = 8'd0; n = n + 4'd1;
                        end
                    end
                end
                if (!skip) begin
                    if (s.a0 != 4'd0) begin
                        ent.codes[n] = {4'd0, s.a0}; n = n + 4'd1;
                    end else if (s.a3 == 4'd0 && s.a2 == 4'd0 && s.a1 == 4'd0) begin
                        ent.codes[n] = 8'd0; n = n + 4'd1;
                    end
                end
                if (s.dec != 4'd0) begin
                    ent.codes[n] = CODE_POINT; n = n + 4'd1;
                    ent.codes[n] = {4'd0, s.dec}; n = n + 4'd1;
                end
            end
            default: begin
                n = '0;
            end
        endcase
        ent.cnt = n;
    end

    // Requests that speak nothing are dropped here.
    assign q_push  = vld_reg[NSTG-1] && !q_full && (ent.cnt != '0);
    assign q_entry = ent;

endmodule

@@ rtl/core/nsc_queue.sv @@
// Small request queue between the front end and the back end.
// Holds fully expanded clip lists; depends on nsc_pkg.
module nsc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nsc_pkg::entry_t wr_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output nsc_pkg::entry_t rd_entry
);
    import nsc_pkg::*;

    entry_t          mem [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full     = (fill_reg == (QAW+1)'(QDEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/core/nsc_back.sv @@
// Back end: walks the clip list at the queue head and drives the
// registered result channel, one clip per beat. Depends on nsc_pkg.
module nsc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  nsc_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_voice_code,
    output logic [7:0]      m_gap_ms,
    output logic            m_last
);
    import nsc_pkg::*;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       gap_reg, gap_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_end;

    // The output register can take a new beat when empty or being drained.
    assign load   = !valid_reg || m_ready;
    assign at_end = (idx_reg == q_entry.cnt - 1'b1);
    assign q_pop  = load && !q_empty && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        code_next  = code_reg;
        gap_next   = gap_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                code_next = q_entry.codes[idx_reg];
                gap_next  = q_entry.gap;
                last_next = at_end;
                idx_next  = at_end ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        gap_reg  <= gap_next;
        last_reg <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_voice_code = code_reg;
    assign m_gap_ms     = gap_reg;
    assign m_last       = last_reg;

endmodule

@@ rtl/core/number_to_spoken_code_sequencer_unit.sv @@
// Spoken-number clip sequencer, top level.
// Usage:
//   The s_ channel takes one play request per beat: a request type, a value
//   and a word gap. Type 0 passes the low byte of the value as one clip,
//   type 1 reads a signed integer, type 2 a signed value in tenths; type 3
//   produces nothing. Only units through thousands of the integer part are
//   spoken.
//   The m_ channel gives one clip code per beat with the request's gap;
//   m_last marks the final clip of a request.
//   An accepted request passes a six-stage digit pipeline, whose first stage
//   loads at the accepting edge and takes the magnitude while each later
//   stage does one divide-by-ten multiply (the second only for tenths),
//   then one queue write and the output register. The clips of a request,
//   one to ten of them, then stream out one per cycle while the receiver is
//   ready; the front end accepts one request per cycle while s_ready is high.
//   A four-entry queue sits between the two halves. When the receiver
//   stalls, the output register holds its beat, the queue fills, and
//   s_ready drops once the queue is full and a request waits in the last
//   pipeline stage.
//   Reset (aresetn low, synchronous) empties the pipeline, the queue and
//   the output register.
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
module number_to_spoken_code_sequencer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [17:0] s_value,
    input  logic [7:0]         s_word_gap_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_voice_code,
    output logic [7:0]         m_gap_ms,
    output logic               m_last
);
    import nsc_pkg::*;

    entry_t wr_entry;
    entry_t rd_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    nsc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .s_word_gap_ms (s_word_gap_ms),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (wr_entry)
    );

    nsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .rd_entry (rd_entry)
    );

    nsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_entry      (rd_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_voice_code (m_voice_code),
        .m_gap_ms     (m_gap_ms),
        .m_last       (m_last)
    );

endmodule

@@ sim/number_to_spoken_code_sequencer_unit_test.sv @@
// Self-checking bench for the spoken-number clip sequencer: a directed table and then
// random requests, with every clip checked against the table or a predictor of the spoken reading.
// Depends on nsc_pkg and number_to_spoken_code_sequencer_unit.
`timescale 1ns / 100ps

module number_to_spoken_code_sequencer_unit_test;
    import nsc_pkg::*;

    localparam int         RANDOM_ITEMS  = 300;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         TAIL_CYCLES   = 32;
    localparam logic [4:0] UNTYPED       = 5'd31;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] gap;
        logic       last;
    } clip_t;

    // One row of the directed table. When gold_n is not UNTYPED, gold holds the
    // clips in speaking order, first clip in the most significant used byte.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [17:0] value;
        logic [7:0]  gap;
        logic [4:0]  gold_n;
        logic [79:0] gold;
    } spoken_row_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type    = REQ_RAW;
    logic signed [17:0] s_value       = '0;
    logic [7:0]         s_word_gap_ms = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [7:0]         m_voice_code;
    logic [7:0]         m_gap_ms;
    logic               m_last;

    clip_t       pending_clips [$];
    spoken_row_t directed_rows [$];
    logic [7:0]  spoken [0:MAX_CODES-1];
    int          spoken_n;
    int          mismatch_count = 0;
    bit          idle_en        = 1'b1;
    bit          hold_off_req   = 1'b0;
    clip_t       want;
    clip_t       got;

    number_to_spoken_code_sequencer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .s_word_gap_ms (s_word_gap_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_voice_code  (m_voice_code),
        .m_gap_ms      (m_gap_ms),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic spoken_row_t stim_row(input logic [1:0] t, input int v,
                                             input logic [7:0] g, input logic [4:0] n,
                                             input logic [79:0] gold);
        spoken_row_t r;
        r.req_type = t;
        r.value    = v[17:0];
        r.gap      = g;
        r.gold_n   = n;
        r.gold     = gold;
        return r;
    endfunction

    function automatic void say(input logic [7:0] code);
        spoken[spoken_n] = code;
        spoken_n++;
    endfunction

    // Moves the clips gathered in the scratch list onto the queue of pending
    // clips, marking the final one of the request.
    function automatic void commit_spoken(input logic [7:0] gap);
        clip_t c;
        for (int i = 0; i < spoken_n; i++) begin
            c.code = spoken[i];
            c.gap  = gap;
            c.last = (i == spoken_n - 1);
            pending_clips.push_back(c);
        end
        spoken_n = 0;
    endfunction

    function automatic void queue_gold(input spoken_row_t r);
        for (int i = 0; i < r.gold_n; i++) begin
            say(r.gold[8 * (r.gold_n - 1 - i) +: 8]);
        end
        commit_spoken(r.gap);
    endfunction

    // Works out the clips that read one request aloud.
    function automatic void predict_reading(input logic [1:0] t, input logic signed [17:0] v,
                                            input logic [7:0] g);
        logic        neg;
        logic [17:0] mag;
        int unsigned whole, tenth, d3, d2, d1, d0;
        bit          done;
        spoken_n = 0;
        if (t == REQ_NONE) begin
            return;
        end
        if (t == REQ_RAW) begin
            say(v[7:0]);
            commit_spoken(g);
            return;
        end
        neg = v[17];
        mag = neg ? 18'd0 - v : v;
        if (t == REQ_TENTHS) begin
            whole = mag / 10;
            tenth = mag % 10;
        end else begin
            whole = mag;
            tenth = 0;
        end
        d3 = (whole / 1000) % 10;
        d2 = (whole / 100) % 10;
        d1 = (whole / 10) % 10;
        d0 = whole % 10;
        done = 1'b0;
        if (neg) begin
            say(CODE_MINUS);
        end
        if (d3 != 0) begin
            say(d3[7:0]);
            say(CODE_THOUSAND);
        end
        if (d2 != 0) begin
            say(d2[7:0]);
            say(CODE_HUNDRED);
        end else if (d3 != 0) begin
            if (d1 == 0 && d0 == 0) begin
                done = 1'b1;
            end else begin
                say(8'd0);
            end
        end
        if (!done) begin
            // A bare ten drops its leading one.
            if (d1 != 0) begin
                if (d1 != 1 || d3 != 0 || d2 != 0) begin
                    say(d1[7:0]);
                end
                say(CODE_TEN);
            end else if (d2 != 0) begin
                if (d0 == 0) begin
                    done = 1'b1;
                end else begin
                    say(8'd0);
                end
            end
        end
        if (!done) begin
            if (d0 != 0) begin
                say(d0[7:0]);
            end else if (d3 == 0 && d2 == 0 && d1 == 0) begin
                say(8'd0);
            end
        end
        if (tenth != 0) begin
            say(CODE_POINT);
            say(tenth[7:0]);
        end
        commit_spoken(g);
    endfunction

    // Mostly numbers built digit by digit with many zero places, so that the zero
    // insertion and the skipped trailing places come up often; else any 18-bit value.
    function automatic logic signed [17:0] random_number();
        int unsigned m;
        int unsigned d;
        if ($urandom_range(0, 9) < 3) begin
            return $signed(18'($urandom_range(0, 18'h3FFFF)));
        end
        m = 0;
        for (int i = 0; i < 5; i++) begin
            d = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            m = m * 10 + d;
        end
        case ($urandom_range(0, 4))
            0: m = m % 10;
            1: m = m % 100;
            2: m = m % 1000;
            3: m = m % 10000;
            default: ;
        endcase
        return $urandom_range(0, 1) ? -$signed(m[17:0]) : $signed(m[17:0]);
    endfunction

    function automatic logic [1:0] random_type();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            return REQ_RAW;
        end else if (pick < 3) begin
            return REQ_NONE;
        end else if (pick < 12) begin
            return REQ_INT;
        end
        return REQ_TENTHS;
    endfunction

    // Offers one request and returns at the edge where it is accepted.
    task automatic offer(input logic [1:0] t, input logic signed [17:0] v,
                         input logic [7:0] g);
        while (idle_en && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= t;
        s_value       <= v;
        s_word_gap_ms <= g;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_clips.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic void note_mismatch(input string what, input clip_t exp_clip,
                                          input clip_t act_clip);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected code %0d gap %0d last %0b, got code %0d gap %0d last %0b",
                     $realtime, what, exp_clip.code, exp_clip.gap, exp_clip.last,
                     act_clip.code, act_clip.gap, act_clip.last);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.code = m_voice_code;
            got.gap  = m_gap_ms;
            got.last = m_last;
            if (pending_clips.size() == 0) begin
                note_mismatch("clip beat with nothing pending", '0, got);
            end else begin
                want = pending_clips.pop_front();
                if (got != want) begin
                    note_mismatch("clip beat mismatch", want, got);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= !(idle_en && $urandom_range(0, 99) < 8);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        spoken_row_t        r;
        logic [1:0]         t;
        logic signed [17:0] v;
        directed_rows.push_back(stim_row(REQ_RAW,    255,     8'd0,   5'd1, 'hFF));
        directed_rows.push_back(stim_row(REQ_RAW,    -1,      8'd255, 5'd1, 'hFF));
        directed_rows.push_back(stim_row(REQ_RAW,    0,       8'd1,   5'd1, 'h00));
        directed_rows.push_back(stim_row(REQ_RAW,    131071,  8'd128, UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_NONE,   1234,    8'd7,   5'd0, '0));
        directed_rows.push_back(stim_row(REQ_INT,    0,       8'd0,   5'd1, 'h00));
        directed_rows.push_back(stim_row(REQ_INT,    10,      8'd9,   5'd1, 'h0E));
        directed_rows.push_back(stim_row(REQ_INT,    -1,      8'd20,  5'd2, 'h0A01));
        directed_rows.push_back(stim_row(REQ_INT,    15,      8'd33,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    101,     8'd40,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    1001,    8'd50,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    1010,    8'd60,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    1100,    8'd70,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    2000,    8'd80,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    3020,    8'd90,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    10000,   8'd100, 5'd1, 'h00));
        directed_rows.push_back(stim_row(REQ_INT,    99999,   8'd255, 5'd7, 'h090C090D090E09));
        directed_rows.push_back(stim_row(REQ_INT,    -99999,  8'd254, UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    131071,  8'd170, UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_INT,    -131072, 8'd85,  UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_TENTHS, -5,      8'd3,   5'd4, 'h0A000B05));
        directed_rows.push_back(stim_row(REQ_TENTHS, 0,       8'd4,   5'd1, 'h00));
        directed_rows.push_back(stim_row(REQ_TENTHS, 120,     8'd5,   UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_TENTHS, 99999,   8'd6,   UNTYPED, '0));
        directed_rows.push_back(stim_row(REQ_TENTHS, -131072, 8'd8,   UNTYPED, '0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            offer(r.req_type, r.value, r.gap);
            if (r.gold_n == UNTYPED) begin
                predict_reading(r.req_type, r.value, r.gap);
            end else begin
                queue_gold(r);
            end
        end
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            idle_en = !(k >= 120 && k < 200);
            // The receiver holds off while requests keep coming, filling the queue.
            if (k == 60) begin
                hold_off_req = 1'b1;
            end
            t = random_type();
            if (t == REQ_RAW || t == REQ_NONE) begin
                v = $signed(18'($urandom_range(0, 18'h3FFFF)));
            end else begin
                v = random_number();
            end
            r.gap = 8'($urandom_range(0, 255));
            offer(t, v, r.gap);
            predict_reading(t, v, r.gap);
            if (k == 250) begin
                drain();
            end
        end
        s_valid <= 1'b0;

        while (pending_clips.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/nsc_pkg.sv
rtl/core/nsc_front.sv
rtl/core/nsc_queue.sv
rtl/core/nsc_back.sv
rtl/core/number_to_spoken_code_sequencer_unit.sv
sim/number_to_spoken_code_sequencer_unit_test.sv
